>>> rtl/core/arre_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the array range reverse engine.
// No dependencies; used by arre_mem, arre_ctrl and the top level.
package arre_pkg;

	localparam int IDX_W  = 10;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		REQ_WRITE   = 2'd0,
		REQ_REVERSE = 2'd1,
		REQ_READ    = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD_WAIT,
		ST_SWAP_RD,
		ST_SWAP_WR
	} state_t;

	// Per-port enables of the dual-port element memory.
	typedef struct packed {
		logic en_a;
		logic we_a;
		logic en_b;
		logic we_b;
	} mem_cmd_t;

endpackage

>>> rtl/core/arre_mem.sv
`timescale 1ns / 1ps
// True dual-port element memory with registered read data on both ports.
// Depends on arre_pkg for the command struct and the data width.
module arre_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                        clk,
	input  arre_pkg::mem_cmd_t          cmd,
	input  logic [AW-1:0]               addr_a,
	input  logic [arre_pkg::DATA_W-1:0] wdata_a,
	output logic [arre_pkg::DATA_W-1:0] rdata_a,
	input  logic [AW-1:0]               addr_b,
	input  logic [arre_pkg::DATA_W-1:0] wdata_b,
	output logic [arre_pkg::DATA_W-1:0] rdata_b
);

	logic [arre_pkg::DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (cmd.en_a) begin
			if (cmd.we_a) begin
				mem[addr_a] <= wdata_a;
			end else begin
				rdata_a <= mem[addr_a];
			end
		end
		if (cmd.en_b) begin
			if (cmd.we_b) begin
				mem[addr_b] <= wdata_b;
			end else begin
				rdata_b <= mem[addr_b];
			end
		end
	end

endmodule

>>> rtl/core/arre_ctrl.sv
`timescale 1ns / 1ps
// Request sequencer: decodes requests, runs the swap loop over the memory
// and holds the result register. Depends on arre_pkg.
module arre_ctrl #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         req_type,
	input  logic [arre_pkg::IDX_W-1:0]         first_index,
	input  logic [arre_pkg::IDX_W-1:0]         last_index,
	input  logic signed [arre_pkg::DATA_W-1:0] write_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [arre_pkg::DATA_W-1:0] read_value,
	output arre_pkg::mem_cmd_t                 cmd,
	output logic [AW-1:0]                      addr_a,
	output logic [arre_pkg::DATA_W-1:0]        wdata_a,
	input  logic [arre_pkg::DATA_W-1:0]        rdata_a,
	output logic [AW-1:0]                      addr_b,
	output logic [arre_pkg::DATA_W-1:0]        wdata_b,
	input  logic [arre_pkg::DATA_W-1:0]        rdata_b
);

	// Compare width wide enough for both the index fields and DEPTH itself.
	localparam int CW = ((AW > arre_pkg::IDX_W) ? AW : arre_pkg::IDX_W) + 1;

	arre_pkg::state_t state_q, state_d;
	logic [AW-1:0] lo_q, hi_q;
	logic          zero_q;
	logic          out_valid_q;
	logic [arre_pkg::DATA_W-1:0] rv_q;

	logic [CW-1:0] first_ext, last_ext;
	logic          first_ok, last_ok, accept, load_range, load_read;
	logic [AW-1:0] lo_inc, hi_dec;

	assign first_ext = CW'(first_index);
	assign last_ext  = CW'(last_index);
	assign first_ok  = first_ext < CW'(DEPTH);
	assign last_ok   = last_ext < CW'(DEPTH);
	assign lo_inc    = lo_q + AW'(1);
	assign hi_dec    = hi_q - AW'(1);

	assign in_ready  = (state_q == arre_pkg::ST_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign read_value = rv_q;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		addr_a     = lo_q;
		addr_b     = hi_q;
		wdata_a    = rdata_b;
		wdata_b    = rdata_a;
		load_range = 1'b0;
		load_read  = 1'b0;
		unique case (state_q)
			arre_pkg::ST_IDLE: begin
				addr_a  = first_ext[AW-1:0];
				wdata_a = write_value;
				if (accept) begin
					unique case (arre_pkg::req_t'(req_type))
						arre_pkg::REQ_WRITE: begin
							cmd.en_a = first_ok;
							cmd.we_a = first_ok;
						end
						arre_pkg::REQ_REVERSE: begin
							if (first_ok && last_ok && (first_ext < last_ext)) begin
								load_range = 1'b1;
								state_d    = arre_pkg::ST_SWAP_RD;
							end
						end
						arre_pkg::REQ_READ: begin
							cmd.en_a  = first_ok;
							load_read = 1'b1;
							state_d   = arre_pkg::ST_RD_WAIT;
						end
						default: begin
						end
					endcase
				end
			end
			arre_pkg::ST_RD_WAIT: begin
				state_d = arre_pkg::ST_IDLE;
			end
			arre_pkg::ST_SWAP_RD: begin
				cmd.en_a = 1'b1;
				cmd.en_b = 1'b1;
				state_d  = arre_pkg::ST_SWAP_WR;
			end
			arre_pkg::ST_SWAP_WR: begin
				cmd.en_a = 1'b1;
				cmd.we_a = 1'b1;
				cmd.en_b = 1'b1;
				cmd.we_b = 1'b1;
				state_d  = (lo_inc < hi_dec) ? arre_pkg::ST_SWAP_RD : arre_pkg::ST_IDLE;
			end
			default: begin
				state_d = arre_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= arre_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == arre_pkg::ST_RD_WAIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_range) begin
			lo_q <= first_ext[AW-1:0];
			hi_q <= last_ext[AW-1:0];
		end else if (state_q == arre_pkg::ST_SWAP_WR) begin
			lo_q <= lo_inc;
			hi_q <= hi_dec;
		end
		if (load_read) begin
			zero_q <= !first_ok;
		end
		if (state_q == arre_pkg::ST_RD_WAIT) begin
			rv_q <= zero_q ? '0 : rdata_a;
		end
	end

	// A swap read is always followed by its write-back.
	a_swap_pair: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == arre_pkg::ST_SWAP_RD |=> state_q == arre_pkg::ST_SWAP_WR)
		else $error("swap read not followed by write-back");

	// Both ports never write the same entry in one cycle.
	a_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.we_a && cmd.we_b |-> addr_a != addr_b)
		else $error("dual write to one entry");

	// The swap pointers stay ordered while the loop runs.
	a_ptr_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == arre_pkg::ST_SWAP_RD |-> lo_q < hi_q)
		else $error("swap pointers crossed");

	// A read always presents its beat on the cycle after the memory returns.
	a_read_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == arre_pkg::ST_RD_WAIT |=> out_valid)
		else $error("read result not presented");

	// No request is taken while a read or a reverse is running.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != arre_pkg::ST_IDLE |-> !in_ready)
		else $error("request accepted while busy");

endmodule

>>> rtl/core/array_range_reverse_engine_unit.sv
`timescale 1ns / 1ps
// A write is committed on acceptance; a read presents its beat after the memory read
// register and then the result register load. A reverse of first..last does
// floor((last-first+1)/2) swaps; each reads both ends on both ports, then writes back.
// One request at a time; a beat is taken once the sequencer is idle and no result waits.
// Reset (arst_n, asynchronous, active low) clears the sequencer and the output valid;
// the element memory is not cleared and holds undefined data until written.
module array_range_reverse_engine_unit #(
	parameter int DEPTH = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         req_type,
	input  logic [arre_pkg::IDX_W-1:0]         first_index,
	input  logic [arre_pkg::IDX_W-1:0]         last_index,
	input  logic signed [arre_pkg::DATA_W-1:0] write_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [arre_pkg::DATA_W-1:0] read_value
);

	// Address width of the element memory follows the depth.
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	arre_pkg::mem_cmd_t          cmd;
	logic [AW-1:0]               addr_a, addr_b;
	logic [arre_pkg::DATA_W-1:0] wdata_a, wdata_b, rdata_a, rdata_b;

	// The sequencer owns both memory ports. Port A serves single writes
	// and reads; during a reverse, port A walks up from the first index
	// and port B walks down from the last index, crossing the read data
	// over on the write-back cycle.
	arre_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.first_index (first_index),
		.last_index  (last_index),
		.write_value (write_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.read_value  (read_value),
		.cmd         (cmd),
		.addr_a      (addr_a),
		.wdata_a     (wdata_a),
		.rdata_a     (rdata_a),
		.addr_b      (addr_b),
		.wdata_b     (wdata_b),
		.rdata_b     (rdata_b)
	);

	// Element store: synchronous dual-port memory with registered read data.
	arre_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.cmd     (cmd),
		.addr_a  (addr_a),
		.wdata_a (wdata_a),
		.rdata_a (rdata_a),
		.addr_b  (addr_b),
		.wdata_b (wdata_b),
		.rdata_b (rdata_b)
	);

endmodule
